// ===== src/dds_ifl_pkg.sv =====
// Shared types and constants of the IF frequency lock controller.
package dds_ifl_pkg;

    // Control modes, one-hot
    typedef enum logic [4:0] {
        MODE_WAIT   = 5'b00001,
        MODE_COARSE = 5'b00010,
        MODE_COMP   = 5'b00100,
        MODE_HOLD   = 5'b01000,
        MODE_ERR    = 5'b10000
    } t_mode;

    // Codes reported in loop_state
    localparam logic [2:0] LOOP_WAIT   = 3'd0;
    localparam logic [2:0] LOOP_COARSE = 3'd1;
    localparam logic [2:0] LOOP_COMP   = 3'd2;
    localparam logic [2:0] LOOP_HOLD   = 3'd3;
    localparam logic [2:0] LOOP_ERR    = 3'd4;

    // Register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_MIN_INPUT  = 3'd0;
    localparam logic [2:0] REG_MAX_INPUT  = 3'd1;
    localparam logic [2:0] REG_TARGET_IF  = 3'd2;
    localparam logic [2:0] REG_MAX_OUTPUT = 3'd3;
    localparam logic [2:0] REG_CORR_LIMIT = 3'd4;

    // Register reset values
    localparam logic [26:0] RST_MIN_INPUT  = 27'd1000000;
    localparam logic [26:0] RST_MAX_INPUT  = 27'd30000000;
    localparam logic [26:0] RST_TARGET_IF  = 27'd100000;
    localparam logic [26:0] RST_MAX_OUTPUT = 27'd37500000;
    localparam logic [2:0]  RST_CORR_LIMIT = 3'd5;

    localparam int unsigned IN_BITS   = 96;
    localparam int unsigned OUT_BITS  = 80;
    localparam int unsigned ADDR_BITS = 5;

    localparam logic [15:0] FAULT_MAX = 16'hFFFF;
    localparam logic [2:0]  CORR_MAX  = 3'd7;

    // Input item layout, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] result_seq;
        logic [26:0] if_hz;
        logic        freq_field_valid;
        logic        result_valid;
        logic        snapshot_present;
        logic [26:0] coarse_hz;
        logic        restart;
    } t_in_item;

    // Result item layout, lowest field last
    typedef struct packed {
        logic               pad;
        logic [15:0]        fault_count;
        logic signed [27:0] if_error_hz;
        logic [2:0]         corrections_done;
        logic [2:0]         loop_state;
        logic               resync_request;
        logic [26:0]        synth_hz;
        logic               write_synth;
    } t_out_item;

endpackage

// ===== src/dds_if_frequency_lock.sv =====
// Top level of the IF frequency lock controller.
//
// Each input item on the s_axis channel is one control pass; each pass
// yields exactly one result item on the m_axis channel. A restart request
// starts a coarse step that sets the oscillator to the coarse input
// frequency minus the target IF; later fresh, valid IF snapshots add the
// IF error to the oscillator until correction_limit corrections are done,
// then the loop holds. Range violations count a saturating fault and park
// the loop in the error state until the next restart.
// An item is registered in the input register, and its result is loaded
// into the output register when that register is free or being drained.
// Throughput: one item per cycle while the receiver takes results; the
// control state update is a single compare-and-add between the input and
// result registers. A stalled receiver holds the result register; the
// input register still takes one more item, and s_axis_tready drops only
// when both are full. Reset clears both stages, puts the loop in waiting
// with all counts, the oscillator frequency and the sequence mark at zero,
// and restores the register defaults. Registers must be written through
// the APB port while idle; the block itself does not enforce this.
module dds_if_frequency_lock (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input pass items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: restart, coarse_hz[27], snapshot_present, result_valid,
    //        freq_field_valid, if_hz[27], result_seq[32], zero pad[6]
    input  logic [dds_ifl_pkg::IN_BITS-1:0]  s_axis_tdata,
    // Result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: write_synth, synth_hz[27], resync_request, loop_state[3],
    //        corrections_done[3], if_error_hz[28], fault_count[16], zero pad[1]
    output logic [dds_ifl_pkg::OUT_BITS-1:0] m_axis_tdata,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dds_ifl_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // Configuration registers
    logic [26:0] r_min_input;
    logic [26:0] r_max_input;
    logic [26:0] r_target_if;
    logic [26:0] r_max_output;
    logic [2:0]  r_corr_limit;

    // Pipeline stages
    logic                    r_in_valid;
    dds_ifl_pkg::t_in_item   r_in_item;
    logic                    r_out_valid;
    dds_ifl_pkg::t_out_item  r_out_item;
    dds_ifl_pkg::t_out_item  n_out_item;
    logic                    advance;

    // Loop state
    dds_ifl_pkg::t_mode r_mode, n_mode;
    logic [26:0]        r_osc, n_osc;
    logic [2:0]         r_count, n_count;
    logic [31:0]        r_seen_seq, n_seen_seq;
    logic signed [27:0] r_last_err, n_last_err;
    logic [15:0]        r_faults, n_faults;

    // Datapath terms
    logic               coarse_ready;
    logic [27:0]        coarse_diff;
    logic               coarse_bad;
    logic               fresh;
    logic signed [27:0] if_err;
    logic signed [28:0] desired;
    logic               desired_bad;
    logic               write_synth;
    logic               resync;
    logic [2:0]         loop_code;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[dds_ifl_pkg::ADDR_BITS-1:2];

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_input  <= dds_ifl_pkg::RST_MIN_INPUT;
            r_max_input  <= dds_ifl_pkg::RST_MAX_INPUT;
            r_target_if  <= dds_ifl_pkg::RST_TARGET_IF;
            r_max_output <= dds_ifl_pkg::RST_MAX_OUTPUT;
            r_corr_limit <= dds_ifl_pkg::RST_CORR_LIMIT;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                dds_ifl_pkg::REG_MIN_INPUT:  r_min_input  <= pwdata[26:0];
                dds_ifl_pkg::REG_MAX_INPUT:  r_max_input  <= pwdata[26:0];
                dds_ifl_pkg::REG_TARGET_IF:  r_target_if  <= pwdata[26:0];
                dds_ifl_pkg::REG_MAX_OUTPUT: r_max_output <= pwdata[26:0];
                dds_ifl_pkg::REG_CORR_LIMIT: r_corr_limit <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // Read back registers
    always_comb begin
        unique case (cfg_idx)
            dds_ifl_pkg::REG_MIN_INPUT:  prdata = {5'd0, r_min_input};
            dds_ifl_pkg::REG_MAX_INPUT:  prdata = {5'd0, r_max_input};
            dds_ifl_pkg::REG_TARGET_IF:  prdata = {5'd0, r_target_if};
            dds_ifl_pkg::REG_MAX_OUTPUT: prdata = {5'd0, r_max_output};
            dds_ifl_pkg::REG_CORR_LIMIT: prdata = {29'd0, r_corr_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    // Move an item on when the result register is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Per-pass control update
    always_comb begin
        n_mode      = r_mode;
        n_osc       = r_osc;
        n_count     = r_count;
        n_seen_seq  = r_seen_seq;
        n_last_err  = r_last_err;
        n_faults    = r_faults;
        write_synth = 1'b0;
        resync      = 1'b0;

        coarse_ready = (r_in_item.coarse_hz != 27'd0)
                    && (r_in_item.coarse_hz >= r_min_input)
                    && (r_in_item.coarse_hz <= r_max_input)
                    && (r_in_item.coarse_hz != r_target_if);
        coarse_diff  = {1'b0, r_in_item.coarse_hz} - {1'b0, r_target_if};
        coarse_bad   = (r_in_item.coarse_hz < r_target_if)
                    || (coarse_diff > {1'b0, r_max_output});

        fresh   = r_in_item.snapshot_present && r_in_item.result_valid
               && r_in_item.freq_field_valid && (r_in_item.if_hz != 27'd0)
               && (r_in_item.result_seq != r_seen_seq);
        if_err  = $signed({1'b0, r_in_item.if_hz}) - $signed({1'b0, r_target_if});
        desired = $signed({2'b00, r_osc}) + $signed({if_err[27], if_err});
        desired_bad = desired[28] || (desired == 29'sd0)
                   || (desired[27:0] > {1'b0, r_max_output});

        // Restart drops back to a coarse step in this pass
        if (r_in_item.restart) begin
            n_count    = 3'd0;
            n_last_err = 28'sd0;
            n_mode     = dds_ifl_pkg::MODE_COARSE;
        end

        if (n_mode == dds_ifl_pkg::MODE_COARSE) begin
            if (coarse_ready) begin
                if (coarse_bad) begin
                    if (r_faults != dds_ifl_pkg::FAULT_MAX) n_faults = r_faults + 16'd1;
                    n_mode = dds_ifl_pkg::MODE_ERR;
                end else begin
                    n_osc       = coarse_diff[26:0];
                    write_synth = 1'b1;
                    n_count     = 3'd0;
                    n_last_err  = 28'sd0;
                    n_seen_seq  = r_in_item.snapshot_present ? r_in_item.result_seq : 32'd0;
                    resync      = 1'b1;
                    n_mode      = dds_ifl_pkg::MODE_COMP;
                end
            end
        end else if (n_mode == dds_ifl_pkg::MODE_COMP) begin
            if (fresh) begin
                n_seen_seq = r_in_item.result_seq;
                n_last_err = if_err;
                if (desired_bad) begin
                    if (r_faults != dds_ifl_pkg::FAULT_MAX) n_faults = r_faults + 16'd1;
                    n_mode = dds_ifl_pkg::MODE_ERR;
                end else begin
                    n_osc       = desired[26:0];
                    write_synth = 1'b1;
                    if (r_count != dds_ifl_pkg::CORR_MAX) n_count = r_count + 3'd1;
                    if (n_count >= r_corr_limit) begin
                        n_mode = dds_ifl_pkg::MODE_HOLD;
                    end else begin
                        resync = 1'b1;
                    end
                end
            end
        end
    end

    // Report code of the new mode
    always_comb begin
        unique case (n_mode)
            dds_ifl_pkg::MODE_WAIT:   loop_code = dds_ifl_pkg::LOOP_WAIT;
            dds_ifl_pkg::MODE_COARSE: loop_code = dds_ifl_pkg::LOOP_COARSE;
            dds_ifl_pkg::MODE_COMP:   loop_code = dds_ifl_pkg::LOOP_COMP;
            dds_ifl_pkg::MODE_HOLD:   loop_code = dds_ifl_pkg::LOOP_HOLD;
            dds_ifl_pkg::MODE_ERR:    loop_code = dds_ifl_pkg::LOOP_ERR;
            default:                  loop_code = dds_ifl_pkg::LOOP_WAIT;
        endcase
    end

    // Assemble the result item
    always_comb begin
        n_out_item                  = '0;
        n_out_item.write_synth      = write_synth;
        n_out_item.synth_hz         = n_osc;
        n_out_item.resync_request   = resync;
        n_out_item.loop_state       = loop_code;
        n_out_item.corrections_done = n_count;
        n_out_item.if_error_hz      = n_last_err;
        n_out_item.fault_count      = n_faults;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= dds_ifl_pkg::t_in_item'(s_axis_tdata);
        end
    end

    // Result register and loop state advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= dds_ifl_pkg::MODE_WAIT;
            r_osc       <= 27'd0;
            r_count     <= 3'd0;
            r_seen_seq  <= 32'd0;
            r_last_err  <= 28'sd0;
            r_faults    <= 16'd0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_mode      <= n_mode;
            r_osc       <= n_osc;
            r_count     <= n_count;
            r_seen_seq  <= n_seen_seq;
            r_last_err  <= n_last_err;
            r_faults    <= n_faults;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_item;

endmodule

// ===== src/dds_ifl_checker.sv =====
// Port-level checker of the IF frequency lock controller and its bind.
module dds_ifl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dds_ifl_pkg::OUT_BITS-1:0]  m_axis_tdata
);

    dds_ifl_pkg::t_out_item res;
    assign res = dds_ifl_pkg::t_out_item'(m_axis_tdata);

    // A stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A synthesizer write only ends in compensating or holding
    a_write_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.write_synth |->
            res.loop_state == dds_ifl_pkg::LOOP_COMP
            || res.loop_state == dds_ifl_pkg::LOOP_HOLD)
        else $error("write outside compensating or holding");

    // Resync comes with a write and keeps compensating
    a_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.resync_request |->
            res.write_synth && res.loop_state == dds_ifl_pkg::LOOP_COMP)
        else $error("resync without write in compensating");

    // Coarse state has no corrections and no error left over
    a_coarse_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.loop_state == dds_ifl_pkg::LOOP_COARSE |->
            res.corrections_done == 3'd0 && res.if_error_hz == 28'sd0)
        else $error("coarse state with stale correction data");

endmodule

bind dds_if_frequency_lock dds_ifl_checker u_dds_ifl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the IF frequency lock controller.
`timescale 1ns / 1ps

module tb;

    localparam longint FREQ_MAX       = 134217727;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     REPORT_LIMIT   = 10;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // tdata: restart, coarse_hz[27], snapshot_present, result_valid,
    //        freq_field_valid, if_hz[27], result_seq[32], zero pad[6]
    logic [dds_ifl_pkg::IN_BITS-1:0]   s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // tdata: write_synth, synth_hz[27], resync_request, loop_state[3],
    //        corrections_done[3], if_error_hz[28], fault_count[16], zero pad[1]
    logic [dds_ifl_pkg::OUT_BITS-1:0]  m_axis_tdata;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [dds_ifl_pkg::ADDR_BITS-1:0] paddr         = '0;
    logic [31:0]                       pwdata        = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    dds_if_frequency_lock DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Register copies used for prediction
    logic [26:0] min_in_hz  = dds_ifl_pkg::RST_MIN_INPUT;
    logic [26:0] max_in_hz  = dds_ifl_pkg::RST_MAX_INPUT;
    logic [26:0] target_if  = dds_ifl_pkg::RST_TARGET_IF;
    logic [26:0] max_out_hz = dds_ifl_pkg::RST_MAX_OUTPUT;
    logic [2:0]  corr_limit = dds_ifl_pkg::RST_CORR_LIMIT;

    // Predicted loop state
    logic [2:0]  loop_mode   = dds_ifl_pkg::LOOP_WAIT;
    logic [26:0] osc_freq    = '0;
    logic [2:0]  corr_count  = '0;
    logic [31:0] seen_seq    = '0;
    longint      last_if_err = 0;
    logic [15:0] fault_total = '0;

    dds_ifl_pkg::t_in_item  pending_passes[$];
    dds_ifl_pkg::t_out_item expected_results[$];

    bit in_taken    = 1'b0;
    bit out_taken   = 1'b0;
    bit idle_on     = 1'b0;
    int in_gap      = 0;
    int out_stall   = 0;
    int fail_count  = 0;
    int idle_cycles = 0;

    function automatic logic [26:0] clip27(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > FREQ_MAX) begin
            return FREQ_MAX[26:0];
        end
        return v[26:0];
    endfunction

    function automatic int draw_idle();
        if (idle_on && $urandom_range(0, 1) == 1) begin
            return $urandom_range(0, 10);
        end
        return 0;
    endfunction

    function automatic void count_fault();
        if (fault_total != dds_ifl_pkg::FAULT_MAX) begin
            fault_total = fault_total + 16'd1;
        end
        loop_mode = dds_ifl_pkg::LOOP_ERR;
    endfunction

    // Advance the loop by one control pass and return the result it yields
    function automatic dds_ifl_pkg::t_out_item predict_pass(input dds_ifl_pkg::t_in_item p);
        dds_ifl_pkg::t_out_item r;
        logic                   wr;
        logic                   rs;
        longint                 desired;
        wr = 1'b0;
        rs = 1'b0;
        if (p.restart) begin
            corr_count  = '0;
            last_if_err = 0;
            loop_mode   = dds_ifl_pkg::LOOP_COARSE;
        end
        if (loop_mode == dds_ifl_pkg::LOOP_COARSE) begin
            if (p.coarse_hz != 0 && p.coarse_hz >= min_in_hz && p.coarse_hz <= max_in_hz
                && p.coarse_hz != target_if) begin
                if (p.coarse_hz < target_if || (p.coarse_hz - target_if) > max_out_hz) begin
                    count_fault();
                end else begin
                    osc_freq    = p.coarse_hz - target_if;
                    wr          = 1'b1;
                    corr_count  = '0;
                    last_if_err = 0;
                    seen_seq    = p.snapshot_present ? p.result_seq : 32'd0;
                    rs          = 1'b1;
                    loop_mode   = dds_ifl_pkg::LOOP_COMP;
                end
            end
        end else if (loop_mode == dds_ifl_pkg::LOOP_COMP) begin
            if (p.snapshot_present && p.result_valid && p.freq_field_valid && p.if_hz != 0
                && p.result_seq != seen_seq) begin
                seen_seq    = p.result_seq;
                last_if_err = longint'(p.if_hz) - longint'(target_if);
                desired     = longint'(osc_freq) + last_if_err;
                if (desired < 1 || desired > longint'(max_out_hz)) begin
                    count_fault();
                end else begin
                    osc_freq = desired[26:0];
                    wr       = 1'b1;
                    if (corr_count < dds_ifl_pkg::CORR_MAX) begin
                        corr_count = corr_count + 3'd1;
                    end
                    if (corr_count >= corr_limit) begin
                        loop_mode = dds_ifl_pkg::LOOP_HOLD;
                    end else begin
                        rs = 1'b1;
                    end
                end
            end
        end
        r.pad              = 1'b0;
        r.write_synth      = wr;
        r.synth_hz         = osc_freq;
        r.resync_request   = rs;
        r.loop_state       = loop_mode;
        r.corrections_done = corr_count;
        r.if_error_hz      = last_if_err[27:0];
        r.fault_count      = fault_total;
        return r;
    endfunction

    function automatic void check_value(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
            end
        end
    endfunction

    // Drive the input items and the result backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || in_taken) begin
                if (in_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    in_gap--;
                end else if (pending_passes.size() != 0) begin
                    s_axis_tdata  <= pending_passes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    in_gap = draw_idle();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (out_taken) begin
                out_stall = draw_idle();
            end
            if (out_stall != 0) begin
                m_axis_tready <= 1'b0;
                out_stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check each result against the oldest prediction, then predict new items
    always @(posedge i_clk) begin : monitor
        dds_ifl_pkg::t_out_item got;
        dds_ifl_pkg::t_out_item want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = dds_ifl_pkg::t_out_item'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result %h at %0t", m_axis_tdata, $realtime);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_value("write_synth", 32'(want.write_synth), 32'(got.write_synth));
                    check_value("synth_hz", 32'(want.synth_hz), 32'(got.synth_hz));
                    check_value("resync_request", 32'(want.resync_request),
                                32'(got.resync_request));
                    check_value("loop_state", 32'(want.loop_state), 32'(got.loop_state));
                    check_value("corrections_done", 32'(want.corrections_done),
                                32'(got.corrections_done));
                    check_value("if_error_hz", {4'd0, want.if_error_hz},
                                {4'd0, got.if_error_hz});
                    check_value("fault_count", 32'(want.fault_count), 32'(got.fault_count));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(
                    predict_pass(dds_ifl_pkg::t_in_item'(s_axis_tdata)));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)
            && !psel) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    // Write one register, then read it back
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            dds_ifl_pkg::REG_MIN_INPUT: begin
                min_in_hz = value[26:0];
                stored    = {5'd0, value[26:0]};
            end
            dds_ifl_pkg::REG_MAX_INPUT: begin
                max_in_hz = value[26:0];
                stored    = {5'd0, value[26:0]};
            end
            dds_ifl_pkg::REG_TARGET_IF: begin
                target_if = value[26:0];
                stored    = {5'd0, value[26:0]};
            end
            dds_ifl_pkg::REG_MAX_OUTPUT: begin
                max_out_hz = value[26:0];
                stored     = {5'd0, value[26:0]};
            end
            dds_ifl_pkg::REG_CORR_LIMIT: begin
                corr_limit = value[2:0];
                stored     = {29'd0, value[2:0]};
            end
            default: begin
                stored = '0;
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_value("register readback", stored, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_cfg(input longint lo, input longint hi, input longint tgt,
                           input longint out_max, input int limit);
        set_reg(dds_ifl_pkg::REG_MIN_INPUT, lo[31:0]);
        set_reg(dds_ifl_pkg::REG_MAX_INPUT, hi[31:0]);
        set_reg(dds_ifl_pkg::REG_TARGET_IF, tgt[31:0]);
        set_reg(dds_ifl_pkg::REG_MAX_OUTPUT, out_max[31:0]);
        set_reg(dds_ifl_pkg::REG_CORR_LIMIT, 32'(limit));
    endtask

    task automatic add_pass(input bit rs, input longint coarse, input bit pr, input bit rv,
                            input bit fv, input longint ifv, input logic [31:0] seq);
        dds_ifl_pkg::t_in_item p;
        p.pad              = '0;
        p.restart          = rs;
        p.coarse_hz        = clip27(coarse);
        p.snapshot_present = pr;
        p.result_valid     = rv;
        p.freq_field_valid = fv;
        p.if_hz            = clip27(ifv);
        p.result_seq       = seq;
        pending_passes.push_back(p);
    endtask

    task automatic add_noise();
        logic [31:0] bits;
        bits = $urandom;
        add_pass($urandom_range(0, 7) == 0, $urandom & FREQ_MAX, bits[0], bits[1], bits[2],
                 $urandom & FREQ_MAX, $urandom);
    endtask

    // Queue a restart followed by a run of IF snapshots with random content
    task automatic add_lock_run();
        longint      coarse;
        longint      span;
        longint      ifv;
        logic [31:0] seq;
        int          n;
        int          pick;
        bit          rs;
        bit          pr;
        bit          rv;
        bit          fv;
        case ($urandom_range(0, 9))
            0:       coarse = 0;
            1:       coarse = longint'(target_if);
            2:       coarse = $urandom & FREQ_MAX;
            3:       coarse = $urandom_range(max_in_hz, min_in_hz);
            default: coarse = longint'(target_if) + $urandom_range(max_out_hz, 1);
        endcase
        seq = $urandom;
        add_pass(1'b1, coarse, $urandom_range(0, 3) != 0, $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom & FREQ_MAX, seq);
        case ($urandom_range(0, 2))
            0:       span = 1000;
            1:       span = longint'(max_out_hz) / 8 + 1;
            default: span = longint'(max_out_hz);
        endcase
        n = $urandom_range(1, corr_limit + 3);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 19);
            rs   = pick == 5;
            pr   = pick != 1;
            rv   = pick != 2;
            fv   = pick != 3;
            if (pick != 0) begin
                seq = seq + 32'd1;
            end
            ifv = longint'(target_if) + longint'($urandom_range(2 * span, 0)) - span;
            if (pick == 4) begin
                ifv = 0;
            end
            add_pass(rs, $urandom_range(0, 1) ? coarse : longint'($urandom & FREQ_MAX),
                     pr, rv, fv, ifv, seq);
        end
    endtask

    task automatic add_random(input int count);
        int goal;
        goal = pending_passes.size() + count;
        while (pending_passes.size() < goal) begin
            if ($urandom_range(0, 19) < 17) begin
                add_lock_run();
            end else begin
                add_noise();
            end
        end
    endtask

    // Hold until every queued item went in and every result came out
    task automatic drain();
        while (pending_passes.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: not ready, lock, stale and invalid snapshots, hold, fault
        idle_on = 1'b1;
        add_pass(0, FREQ_MAX, 1, 1, 1, FREQ_MAX, 32'hFFFF_FFFF);
        add_pass(1, 0, 0, 0, 0, 0, 0);
        add_pass(0, 999999, 0, 0, 0, 0, 0);
        add_pass(0, 30000001, 0, 0, 0, 0, 0);
        add_pass(0, 10000000, 1, 1, 1, 100500, 5);
        add_pass(0, 0, 1, 1, 1, 100500, 5);
        add_pass(0, 0, 1, 0, 1, 100500, 6);
        add_pass(0, 0, 1, 1, 1, 0, 6);
        add_pass(0, 0, 1, 1, 1, 100500, 6);
        add_pass(0, 0, 1, 1, 1, 99000, 7);
        add_pass(0, 0, 1, 1, 1, 100001, 8);
        add_pass(0, 0, 1, 1, 1, 99999, 9);
        add_pass(0, 0, 1, 1, 1, 100000, 10);
        add_pass(0, 0, 1, 1, 1, 100500, 11);
        add_pass(1, 30000000, 0, 1, 1, 0, 0);
        add_pass(0, 0, 1, 1, 1, FREQ_MAX, 1);
        add_pass(0, 0, 1, 1, 1, 100500, 2);
        drain();

        // Tight range, zero limit: coarse faults, boundaries, low and high faults
        set_cfg(1, FREQ_MAX, 1000, 5000, 0);
        idle_on = 1'b0;
        add_pass(1, 500, 0, 0, 0, 0, 0);
        add_pass(1, 1000, 0, 0, 0, 0, 0);
        add_pass(0, 6001, 0, 0, 0, 0, 0);
        add_pass(1, 6000, 1, 1, 1, 0, 32'hFFFF_FFFF);
        add_pass(0, 0, 1, 1, 1, 1, 0);
        add_pass(1, 1500, 0, 0, 0, 0, 0);
        add_pass(0, 0, 1, 1, 1, 1, 7);
        add_pass(1, 2000, 0, 0, 0, 0, 0);
        add_pass(0, 0, 1, 1, 1, 1, 3);
        add_pass(1, 2000, 0, 0, 0, 0, 0);
        add_pass(0, 0, 1, 1, 1, 5001, 4);
        add_pass(1, FREQ_MAX, 0, 0, 0, 0, 0);
        drain();

        // Random phases over a spread of register settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_cfg(dds_ifl_pkg::RST_MIN_INPUT, dds_ifl_pkg::RST_MAX_INPUT,
                           dds_ifl_pkg::RST_TARGET_IF, dds_ifl_pkg::RST_MAX_OUTPUT,
                           $urandom_range(1, 7));
                1: set_cfg(1, 20000, 1000, 10000, 7);
                2: set_cfg(0, FREQ_MAX, 0, FREQ_MAX, 1);
                3: set_cfg(5000000, 5000000, 4000000, 2000000, 3);
                4: set_cfg(0, FREQ_MAX, 1000, 1, 2);
                5: set_cfg(0, FREQ_MAX, FREQ_MAX, FREQ_MAX, 4);
                default: begin
                    min_in_hz = 27'($urandom_range(0, 1 << 26));
                    set_cfg(longint'(min_in_hz),
                            longint'(min_in_hz) + $urandom_range(0, 1 << 26),
                            $urandom_range(0, 1 << 20), $urandom_range(1, FREQ_MAX),
                            $urandom_range(1, 7));
                end
            endcase
            idle_on = ph[0];
            add_random(140);
            drain();
        end

        // Close with a short random run under idle gaps
        idle_on = 1'b1;
        add_random(40);
        drain();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
